// ===== sv/integer_to_ascii_any_base_core_defines.svh =====
// Assertion macros used by the RTL controller (itoa_ctrl).
`ifndef INTEGER_TO_ASCII_ANY_BASE_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_ANY_BASE_CORE_DEFINES_SVH

`ifndef SYNTH
`define ITOA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("itoa check failed");
`define ITOA_ASSERT_NEXT(lbl, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("itoa check failed");
`else
`define ITOA_ASSERT(lbl, prop)
`define ITOA_ASSERT_NEXT(lbl, trig, prop)
`endif

`endif

// ===== sv/itoa_pkg.sv =====
package itoa_pkg;

  localparam int VALUE_BITS = 64;
  localparam int STEP_BITS  = 8;
  localparam int CHUNKS     = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W      = CHUNKS * STEP_BITS;
  localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int ADDR_W     = $clog2(VALUE_BITS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DIGIT_W    = 4;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam int FLAG_UNSIGNED = 0;
  localparam int FLAG_LOWER    = 1;

  typedef struct packed {
    logic load;
    logic step;
    logic digit_done;
    logic rd_first;
    logic shift_out;
  } itoa_cmd_t;

  typedef struct packed {
    logic quo_zero;
    logic count_zero;
    logic idx_zero;
    logic out_free;
  } itoa_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + CHAR_W'(d);
    end else if (lower) begin
      c = 7'h61 + CHAR_W'(d - 4'd10);
    end else begin
      c = 7'h41 + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ===== sv/integer_to_ascii_any_base_core.sv =====
// Channel | Handshake            | Beat contents
// in      | in_valid / in_ready  | value, radix, format_flags
// out     | out_valid / out_ready| character, negative, last
//
// The divider retires 8 quotient bits per cycle over a 64-bit dividend for each
// digit. After division, characters go out one per cycle while out_ready
// stays high.
// Reset (rst, synchronous) returns the controller to idle and empties the
// output register. A stalled output holds the current character and the
// digit read-out waits; in_ready is high only while the controller is idle.
module integer_to_ascii_any_base_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [63:0]          value,
  input  logic [itoa_pkg::RADIX_W-1:0] radix,
  input  logic [1:0]                  format_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [itoa_pkg::CHAR_W-1:0] character,
  output logic                        negative,
  output logic                        last
);
  import itoa_pkg::*;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .radix        (radix),
    .format_flags (format_flags),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .character    (character),
    .negative     (negative),
    .last         (last)
  );

endmodule

// ===== sv/itoa_ctrl.sv =====
`include "integer_to_ascii_any_base_core_defines.svh"

module itoa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  itoa_pkg::itoa_sts_t sts,
  output itoa_pkg::itoa_cmd_t cmd
);
  import itoa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state, state_next;
  logic [CHUNK_W-1:0] chunk, chunk_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    chunk_next = chunk;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          chunk_next = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (chunk == '0 && !sts.count_zero && sts.quo_zero) begin
          cmd.rd_first = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.step = 1'b1;
          if (chunk == CHUNK_W'(CHUNKS - 1)) begin
            cmd.digit_done = 1'b1;
            chunk_next     = '0;
          end else begin
            chunk_next = chunk + CHUNK_W'(1);
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.shift_out = 1'b1;
          if (sts.idx_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chunk <= '0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
    end
  end

  `ITOA_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.step, cmd.rd_first, cmd.shift_out}))
  `ITOA_ASSERT(a_done_in_step, !cmd.digit_done || cmd.step)
  `ITOA_ASSERT(a_emit_has_digits, state != S_EMIT || !sts.count_zero)
  `ITOA_ASSERT_NEXT(a_first_read_emit, cmd.rd_first, state == S_EMIT)

endmodule

// ===== sv/itoa_dp.sv =====
module itoa_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [63:0]              value,
  input  logic [itoa_pkg::RADIX_W-1:0]    radix,
  input  logic [1:0]                      format_flags,
  input  itoa_pkg::itoa_cmd_t             cmd,
  output itoa_pkg::itoa_sts_t             sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]     character,
  output logic                            negative,
  output logic                            last
);
  import itoa_pkg::*;

  logic [PAD_W-1:0]   quo, quo_step;
  logic [DIGIT_W-1:0] rem, rem_step;
  logic [RADIX_W-1:0] base;
  logic               neg, lower;
  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  idx;
  logic [DIGIT_W-1:0] rd_data;
  logic [DIGIT_W-1:0] digit_mem [VALUE_BITS];

  logic [VALUE_BITS-1:0] v_in, mag;
  logic                  in_neg;
  logic [RADIX_W-1:0]    base_in;
  logic [STEP_BITS-1:0]  qbits;
  logic [STEP_BITS-1:0]  top_bits;
  logic [RADIX_W-1:0]    r_w;
  logic [ADDR_W-1:0]     last_addr;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;

  assign v_in   = value[VALUE_BITS-1:0];
  assign in_neg = !format_flags[FLAG_UNSIGNED] && v_in[VALUE_BITS-1];
  assign mag    = in_neg ? (~v_in + VALUE_BITS'(1)) : v_in;

  always_comb begin
    if (radix < RADIX_MIN) begin
      base_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_in = RADIX_MAX;
    end else begin
      base_in = radix;
    end
  end

  // restoring division of the next chunk by the base
  assign top_bits = quo[PAD_W-1 -: STEP_BITS];
  always_comb begin
    r_w = '0;
    qbits = '0;
    rem_step = rem;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r_w = {rem_step, top_bits[i]};
      if (r_w >= base) begin
        r_w      = r_w - base;
        qbits[i] = 1'b1;
      end
      rem_step = r_w[DIGIT_W-1:0];
    end
  end
  assign quo_step = (quo << STEP_BITS) | PAD_W'(qbits);

  assign last_addr = ADDR_W'(count - CNT_W'(1));

  assign sts.quo_zero   = (quo == '0);
  assign sts.count_zero = (count == '0);
  assign sts.idx_zero   = (idx == '0);
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo   <= PAD_W'(mag);
      rem   <= '0;
      base  <= base_in;
      neg   <= in_neg;
      lower <= format_flags[FLAG_LOWER];
      count <= '0;
    end else if (cmd.step) begin
      quo <= quo_step;
      if (cmd.digit_done) begin
        rem   <= '0;
        count <= count + CNT_W'(1);
      end else begin
        rem <= rem_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_done) begin
      digit_mem[count[ADDR_W-1:0]] <= rem_step;
    end
  end

  assign rd_en   = cmd.rd_first || (cmd.shift_out && !sts.idx_zero);
  assign rd_addr = cmd.rd_first ? last_addr : (idx - ADDR_W'(1));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= digit_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) begin
      idx <= last_addr;
    end else if (cmd.shift_out && !sts.idx_zero) begin
      idx <= idx - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.shift_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_out) begin
      character <= digit_char(rd_data, lower);
      negative  <= neg && (idx == last_addr);
      last      <= sts.idx_zero;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import itoa_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_PER_PHASE = 120;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              neg;
    logic              last;
  } char_beat_t;

  class digit_stream_board;
    char_beat_t pending_chars[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function void note_number(logic [63:0] v, logic [RADIX_W-1:0] r, logic [1:0] f);
      logic [63:0] mag;
      logic [63:0] base;
      logic [3:0]  digits[64];
      logic        neg;
      logic        lower;
      int          count;
      char_beat_t  b;
      if (r < RADIX_MIN) begin
        base = 64'(RADIX_MIN);
      end else if (r > RADIX_MAX) begin
        base = 64'(RADIX_MAX);
      end else begin
        base = 64'(r);
      end
      lower = f[FLAG_LOWER];
      neg = !f[FLAG_UNSIGNED] && v[63];
      mag = neg ? (64'd0 - v) : v;
      count = 0;
      do begin
        digits[count] = 4'(mag % base);
        count++;
        mag = mag / base;
      end while (mag != 0 && count < 64);
      for (int k = count - 1; k >= 0; k--) begin
        if (digits[k] < 4'd10) begin
          b.ch = 7'h30 + CHAR_W'(digits[k]);
        end else begin
          b.ch = (lower ? 7'h61 : 7'h41) + CHAR_W'(digits[k] - 4'd10);
        end
        b.neg = neg && (k == count - 1);
        b.last = (k == 0);
        pending_chars.push_back(b);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] c, logic n, logic l);
      char_beat_t e;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: char %h negative %b last %b", c, n, l);
        return;
      end
      e = pending_chars.pop_front();
      if (c !== e.ch || n !== e.neg || l !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: char %h/%h negative %b/%b last %b/%b (exp/got)",
                   e.ch, c, e.neg, n, e.last, l);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic signed [63:0]  value;
  logic [RADIX_W-1:0]  radix;
  logic [1:0]          format_flags;
  logic                out_valid;
  logic                out_ready;
  logic [CHAR_W-1:0]   character;
  logic                negative;
  logic                last;

  digit_stream_board board;
  int send_idle;
  int recv_idle;
  int cycles;

  integer_to_ascii_any_base_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .radix(radix),
    .format_flags(format_flags),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .character(character),
    .negative(negative),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_char(character, negative, last);
  end

  task automatic send_number(input logic [63:0] v, input logic [RADIX_W-1:0] r,
                             input logic [1:0] f);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    radix <= r;
    format_flags <= f;
    do @(posedge clk); while (!in_ready);
    board.note_number(v, r, f);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = 64'd0 - (v >> $urandom_range(63));
      2: begin
        case ($urandom_range(3))
          0: v = 64'd0;
          1: v = '1;
          2: v = 64'h8000_0000_0000_0000;
          default: v = 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    if ($urandom_range(9) == 0)
      return RADIX_W'($urandom_range(31));
    return RADIX_W'($urandom_range(16, 2));
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_number(pick_value(), pick_radix(), 2'($urandom_range(3)));
  endtask

  initial begin
    int failures;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    radix = RADIX_MIN;
    format_flags = 2'b00;
    send_idle = 32;
    recv_idle = 74;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_number(64'd0, 5'd10, 2'b00);
    send_number('1, 5'd10, 2'b00);
    send_number('1, 5'd2, 2'b01);
    send_number('1, 5'd16, 2'b11);
    send_number(64'h8000_0000_0000_0000, 5'd2, 2'b00);
    send_number(64'h8000_0000_0000_0000, 5'd16, 2'b01);
    send_number(64'h8000_0000_0000_0000, 5'd10, 2'b10);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 5'd2, 2'b00);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 5'd10, 2'b01);
    send_number(64'hFEDC_BA98_7654_3210, 5'd16, 2'b01);
    send_number(64'hFEDC_BA98_7654_3210, 5'd16, 2'b11);
    send_number(64'hFEDC_BA98_7654_3210, 5'd16, 2'b00);
    send_number(64'd0 - 64'd255, 5'd16, 2'b10);
    send_number(64'd37, 5'd0, 2'b00);
    send_number(64'd37, 5'd1, 2'b00);
    send_number(64'd48879, 5'd17, 2'b00);
    send_number(64'd48879, 5'd31, 2'b10);
    send_number(64'd1234567, 5'd3, 2'b00);
    send_number(64'd0 - 64'd1234567, 5'd7, 2'b00);
    send_number(64'd987654321, 5'd11, 2'b10);
    send_number(64'd987654321, 5'd13, 2'b00);
    send_number(64'd15, 5'd15, 2'b10);
    send_number(64'd0, 5'd2, 2'b11);

    send_random(RANDOM_PER_PHASE);
    send_idle = 74;
    recv_idle = 32;
    send_random(RANDOM_PER_PHASE);
    send_idle = 0;
    recv_idle = 0;
    send_random(RANDOM_PER_PHASE);
    in_valid <= 1'b0;

    while (board.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    failures = board.mismatches;
    if (board.pending_chars.size() != 0) begin
      $display("%0d expected characters never arrived", board.pending_chars.size());
      failures += board.pending_chars.size();
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
